// ===== src/ccti_pkg.sv =====
// ----------------------------------------------------------------------------
// ccti_pkg
// Widths, stage counts and shared types of the circle-circle time-of-impact
// pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package ccti_pkg;

	// port field widths
	localparam int POS_W  = 32;   // positions and velocities, signed
	localparam int RAD_W  = 31;   // radii, unsigned
	localparam int TIME_W = 32;   // impact time, signed

	// internal widths
	localparam int DIFF_W = POS_W + 1;        // relative offset / velocity
	localparam int RSUM_W = RAD_W + 1;        // r1 + r2
	localparam int PROD_W = 2 * DIFF_W;       // one signed square or product
	localparam int B_W    = PROD_W + 1;       // d.w, signed
	localparam int A_W    = 65;               // w.w, unsigned, below 2^65
	localparam int C_W    = PROD_W + 1;       // d.d - R^2, signed
	localparam int LO_W   = 33;               // low limb of a 65 bit magnitude
	localparam int HI_W   = A_W - LO_W;       // high limb
	localparam int SQ_W   = 2 * A_W;          // b^2 and a*|c|
	localparam int DISC_W = SQ_W + 2;         // discriminant, signed, even width
	localparam int ROOT_W = DISC_W / 2;       // floor square root
	localparam int NUM_W  = B_W + 1;          // -(d.w) - root, signed
	localparam int NMAG_W = NUM_W - 1;        // its magnitude
	localparam int Q_W    = TIME_W + 1;       // quotient bits kept

	// pipeline depths
	localparam int QUAD_LAT = 7;
	localparam int DIV_LAT  = Q_W + 2;
	localparam int LAT      = QUAD_LAT + ROOT_W + DIV_LAT;

	// saturation limits
	localparam logic [TIME_W-1:0] TIME_MAX = {1'b0, {(TIME_W-1){1'b1}}};
	localparam logic [TIME_W-1:0] TIME_MIN = {1'b1, {(TIME_W-1){1'b0}}};

	// one input item
	typedef struct packed {
		logic [POS_W-1:0] first_pos_x;
		logic [POS_W-1:0] first_pos_y;
		logic [POS_W-1:0] second_pos_x;
		logic [POS_W-1:0] second_pos_y;
		logic [POS_W-1:0] first_vel_x;
		logic [POS_W-1:0] first_vel_y;
		logic [POS_W-1:0] second_vel_x;
		logic [POS_W-1:0] second_vel_y;
		logic [RAD_W-1:0] first_radius;
		logic [RAD_W-1:0] second_radius;
	} ccti_in_t;

	// per-item status flags
	typedef struct packed {
		logic hit;
		logic still;
	} ccti_flags_t;

	// what rides alongside the square root
	typedef struct packed {
		logic [B_W-1:0] b;
		logic [A_W-1:0] a;
		ccti_flags_t    flags;
	} ccti_side_t;

	// divider result
	typedef struct packed {
		logic           ovf;
		logic           neg;
		logic           rem_nz;
		logic [Q_W-1:0] q;
	} ccti_quot_t;

endpackage

`default_nettype wire

// ===== src/ccti_if.sv =====
// ----------------------------------------------------------------------------
// ccti_if
// Valid/ready channels for circle pairs and for impact results.
// ----------------------------------------------------------------------------
`default_nettype none

interface ccti_in_if;
	logic                                valid;
	logic                                ready;
	logic signed [ccti_pkg::POS_W-1:0]   first_pos_x;
	logic signed [ccti_pkg::POS_W-1:0]   first_pos_y;
	logic signed [ccti_pkg::POS_W-1:0]   second_pos_x;
	logic signed [ccti_pkg::POS_W-1:0]   second_pos_y;
	logic signed [ccti_pkg::POS_W-1:0]   first_vel_x;
	logic signed [ccti_pkg::POS_W-1:0]   first_vel_y;
	logic signed [ccti_pkg::POS_W-1:0]   second_vel_x;
	logic signed [ccti_pkg::POS_W-1:0]   second_vel_y;
	logic        [ccti_pkg::RAD_W-1:0]   first_radius;
	logic        [ccti_pkg::RAD_W-1:0]   second_radius;

	modport source (
		output valid, first_pos_x, first_pos_y, second_pos_x, second_pos_y,
		       first_vel_x, first_vel_y, second_vel_x, second_vel_y,
		       first_radius, second_radius,
		input  ready
	);
	modport sink (
		input  valid, first_pos_x, first_pos_y, second_pos_x, second_pos_y,
		       first_vel_x, first_vel_y, second_vel_x, second_vel_y,
		       first_radius, second_radius,
		output ready
	);
endinterface

interface ccti_out_if;
	logic                                valid;
	logic                                ready;
	logic                                hit;
	logic signed [ccti_pkg::TIME_W-1:0]  impact_time;
	logic                                no_relative_motion;

	modport source (output valid, hit, impact_time, no_relative_motion, input ready);
	modport sink   (input valid, hit, impact_time, no_relative_motion, output ready);
endinterface

`default_nettype wire

// ===== src/circle_circle_time_of_impact.sv =====
// ----------------------------------------------------------------------------
// circle_circle_time_of_impact
// Earliest contact time of two circles moving on straight lines.
// ----------------------------------------------------------------------------
// Takes one circle pair per cycle and returns one result per pair, in order.
// On its way to the output register an accepted pair passes 7 stages that
// form the coefficients and the discriminant, 66 stages that take the square
// root one bit each, and 35 stages that form the numerator and then divide
// by w.w one quotient bit each. The pipeline holds when its result
// has nowhere to go; a two-entry output buffer lets new pairs enter while a
// finished result waits to be taken. Zero relative velocity reports
// no_relative_motion with no hit; a hit before time zero gives a negative time.
`default_nettype none

module circle_circle_time_of_impact #(
	parameter int FRAC_BITS = 16
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	ccti_in_if.sink     pairs,
	ccti_out_if.source  results
);

	localparam int LAT = ccti_pkg::LAT;
	localparam int TW  = ccti_pkg::TIME_W;
	localparam int QW  = ccti_pkg::Q_W;

	logic en;
	logic skid_v_q, out_v_q;

	// pipeline advances whenever the skid slot is free
	assign en          = !skid_v_q;
	assign pairs.ready = en;

	ccti_pkg::ccti_in_t in_d;
	assign in_d.first_pos_x   = pairs.first_pos_x;
	assign in_d.first_pos_y   = pairs.first_pos_y;
	assign in_d.second_pos_x  = pairs.second_pos_x;
	assign in_d.second_pos_y  = pairs.second_pos_y;
	assign in_d.first_vel_x   = pairs.first_vel_x;
	assign in_d.first_vel_y   = pairs.first_vel_y;
	assign in_d.second_vel_x  = pairs.second_vel_x;
	assign in_d.second_vel_y  = pairs.second_vel_y;
	assign in_d.first_radius  = pairs.first_radius;
	assign in_d.second_radius = pairs.second_radius;

	// valid bits, one per stage
	logic [LAT-1:0] vld_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAT-2:0], pairs.valid};
		end
	end

	logic [ccti_pkg::DISC_W-1:0] disc;
	ccti_pkg::ccti_side_t        side_q, side_r;
	logic [ccti_pkg::ROOT_W-1:0] root;
	ccti_pkg::ccti_quot_t        quot;
	ccti_pkg::ccti_flags_t       flags;

	ccti_quad u_quad (
		.clk  (clk),
		.en   (en),
		.in_d (in_d),
		.disc (disc),
		.side (side_q)
	);

	ccti_sqrt u_sqrt (
		.clk      (clk),
		.en       (en),
		.rad      (disc),
		.side_in  (side_q),
		.root     (root),
		.side_out (side_r)
	);

	ccti_div #(.FRAC_BITS(FRAC_BITS)) u_div (
		.clk     (clk),
		.en      (en),
		.root    (root),
		.side_in (side_r),
		.quot    (quot),
		.flags   (flags)
	);

	// rounding toward minus infinity and saturation
	logic [QW:0]     qq;
	logic [QW:0]     qq_neg;
	logic [TW-1:0]   time_n;
	always_comb begin
		qq     = {1'b0, quot.q} + {{QW{1'b0}}, quot.rem_nz};
		qq_neg = -qq;
		if (!flags.hit) begin
			time_n = '0;
		end else if (!quot.neg) begin
			time_n = (quot.ovf || (quot.q[QW-1:TW-1] != '0)) ? ccti_pkg::TIME_MAX
				: quot.q[TW-1:0];
		end else if (quot.ovf || (qq > {2'b0, ccti_pkg::TIME_MIN})) begin
			time_n = ccti_pkg::TIME_MIN;
		end else begin
			time_n = qq_neg[TW-1:0];
		end
	end

	// output register plus skid slot
	logic          out_hit_q, out_still_q, skid_hit_q, skid_still_q;
	logic [TW-1:0] out_time_q, skid_time_q;
	logic          pop, take;

	assign pop  = out_v_q && results.ready;
	assign take = en && vld_q[LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (skid_v_q) begin
			if (pop) begin
				skid_v_q <= 1'b0;
			end
		end else if (take) begin
			if (!out_v_q || pop) begin
				out_v_q <= 1'b1;
			end else begin
				skid_v_q <= 1'b1;
			end
		end else if (pop) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_v_q) begin
			if (pop) begin
				out_hit_q   <= skid_hit_q;
				out_still_q <= skid_still_q;
				out_time_q  <= skid_time_q;
			end
		end else if (take) begin
			if (!out_v_q || pop) begin
				out_hit_q   <= flags.hit;
				out_still_q <= flags.still;
				out_time_q  <= time_n;
			end else begin
				skid_hit_q   <= flags.hit;
				skid_still_q <= flags.still;
				skid_time_q  <= time_n;
			end
		end
	end

	assign results.valid              = out_v_q;
	assign results.hit                = out_hit_q;
	assign results.impact_time        = out_time_q;
	assign results.no_relative_motion = out_still_q;

endmodule

`default_nettype wire

// ===== src/ccti_quad.sv =====
// ----------------------------------------------------------------------------
// ccti_quad
// Front stages: relative motion, quadratic coefficients and discriminant
// (b^2 - a*c), seven register stages.
// ----------------------------------------------------------------------------
`default_nettype none

module ccti_quad (
	input  wire logic                                clk,
	input  wire logic                                en,
	input  wire ccti_pkg::ccti_in_t                  in_d,
	output logic [ccti_pkg::DISC_W-1:0]              disc,
	output ccti_pkg::ccti_side_t                     side
);

	localparam int DW = ccti_pkg::DIFF_W;
	localparam int PW = ccti_pkg::PROD_W;
	localparam int LW = ccti_pkg::LO_W;
	localparam int SW = ccti_pkg::SQ_W;
	localparam int AW = ccti_pkg::A_W;

	// s1: offsets, relative velocity, contact distance
	logic signed [DW-1:0] dx_s1, dy_s1, wx_s1, wy_s1;
	logic [ccti_pkg::RSUM_W-1:0] rsum_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			dx_s1 <= $signed({in_d.first_pos_x[31], in_d.first_pos_x})
				- $signed({in_d.second_pos_x[31], in_d.second_pos_x});
			dy_s1 <= $signed({in_d.first_pos_y[31], in_d.first_pos_y})
				- $signed({in_d.second_pos_y[31], in_d.second_pos_y});
			wx_s1 <= $signed({in_d.first_vel_x[31], in_d.first_vel_x})
				- $signed({in_d.second_vel_x[31], in_d.second_vel_x});
			wy_s1 <= $signed({in_d.first_vel_y[31], in_d.first_vel_y})
				- $signed({in_d.second_vel_y[31], in_d.second_vel_y});
			rsum_s1 <= {1'b0, in_d.first_radius} + {1'b0, in_d.second_radius};
		end
	end

	// s2: seven products
	logic signed [PW-1:0] pxw_s2, pyw_s2, pxx_s2, pyy_s2, pdx_s2, pdy_s2;
	logic [2*ccti_pkg::RSUM_W-1:0] rr_s2;
	logic still_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			pxw_s2   <= dx_s1 * wx_s1;
			pyw_s2   <= dy_s1 * wy_s1;
			pxx_s2   <= wx_s1 * wx_s1;
			pyy_s2   <= wy_s1 * wy_s1;
			pdx_s2   <= dx_s1 * dx_s1;
			pdy_s2   <= dy_s1 * dy_s1;
			rr_s2    <= rsum_s1 * rsum_s1;
			still_s2 <= (wx_s1 == '0) && (wy_s1 == '0);
		end
	end

	// s3: b = d.w, a = w.w, c = d.d - R^2
	logic [ccti_pkg::B_W-1:0] b_s3;
	logic [AW-1:0] a_s3;
	logic [ccti_pkg::C_W-1:0] c_s3;
	logic still_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			b_s3 <= {pxw_s2[PW-1], pxw_s2} + {pyw_s2[PW-1], pyw_s2};
			a_s3 <= {1'b0, pxx_s2[PW-3:0]} + {1'b0, pyy_s2[PW-3:0]};
			c_s3 <= {3'b0, pdx_s2[PW-3:0]} + {3'b0, pdy_s2[PW-3:0]} - {3'b0, rr_s2};
			still_s3 <= still_s2;
		end
	end

	// s4: magnitudes for the wide products
	logic [ccti_pkg::B_W-1:0] b_neg, c_neg;
	assign b_neg = -b_s3;
	assign c_neg = -c_s3;

	logic [AW-1:0] bmag_s4, cmag_s4, a_s4;
	logic [ccti_pkg::B_W-1:0] b_s4;
	logic cneg_s4, still_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			bmag_s4  <= b_s3[ccti_pkg::B_W-1] ? b_neg[AW-1:0] : b_s3[AW-1:0];
			cmag_s4  <= c_s3[ccti_pkg::C_W-1] ? c_neg[AW-1:0] : c_s3[AW-1:0];
			cneg_s4  <= c_s3[ccti_pkg::C_W-1];
			a_s4     <= a_s3;
			b_s4     <= b_s3;
			still_s4 <= still_s3;
		end
	end

	// s5: partial products of b^2 and a*|c|, 33 bit low and 32 bit high limbs
	logic [2*LW-1:0]                  bll_s5, all_s5;
	logic [LW+ccti_pkg::HI_W-1:0]     blh_s5, alh_s5, ahl_s5;
	logic [2*ccti_pkg::HI_W-1:0]      bhh_s5, ahh_s5;
	logic [AW-1:0] a_s5;
	logic [ccti_pkg::B_W-1:0] b_s5;
	logic cneg_s5, still_s5;

	always_ff @(posedge clk) begin
		if (en) begin
			bll_s5   <= bmag_s4[LW-1:0] * bmag_s4[LW-1:0];
			blh_s5   <= bmag_s4[LW-1:0] * bmag_s4[AW-1:LW];
			bhh_s5   <= bmag_s4[AW-1:LW] * bmag_s4[AW-1:LW];
			all_s5   <= a_s4[LW-1:0] * cmag_s4[LW-1:0];
			alh_s5   <= a_s4[LW-1:0] * cmag_s4[AW-1:LW];
			ahl_s5   <= a_s4[AW-1:LW] * cmag_s4[LW-1:0];
			ahh_s5   <= a_s4[AW-1:LW] * cmag_s4[AW-1:LW];
			a_s5     <= a_s4;
			b_s5     <= b_s4;
			cneg_s5  <= cneg_s4;
			still_s5 <= still_s4;
		end
	end

	// s6: recombine limbs
	logic [2*LW-1:0] amid;
	assign amid = {1'b0, alh_s5} + {1'b0, ahl_s5};

	logic [SW-1:0] bsq_s6, ac_s6;
	logic [AW-1:0] a_s6;
	logic [ccti_pkg::B_W-1:0] b_s6;
	logic cneg_s6, still_s6;

	always_ff @(posedge clk) begin
		if (en) begin
			bsq_s6 <= {{(SW-2*LW){1'b0}}, bll_s5}
				+ {{(SW-LW-ccti_pkg::HI_W-LW-1){1'b0}}, blh_s5, {(LW+1){1'b0}}}
				+ {bhh_s5, {(2*LW){1'b0}}};
			ac_s6  <= {{(SW-2*LW){1'b0}}, all_s5}
				+ {{(SW-3*LW){1'b0}}, amid, {LW{1'b0}}}
				+ {ahh_s5, {(2*LW){1'b0}}};
			a_s6     <= a_s5;
			b_s6     <= b_s5;
			cneg_s6  <= cneg_s5;
			still_s6 <= still_s5;
		end
	end

	// s7: discriminant; negative means the paths never reach contact
	logic [ccti_pkg::DISC_W-1:0] dsum;
	assign dsum = cneg_s6 ? ({2'b0, bsq_s6} + {2'b0, ac_s6})
		: ({2'b0, bsq_s6} - {2'b0, ac_s6});

	logic [ccti_pkg::DISC_W-1:0] disc_s7;
	ccti_pkg::ccti_side_t side_s7;

	always_ff @(posedge clk) begin
		if (en) begin
			disc_s7             <= dsum[ccti_pkg::DISC_W-1] ? '0 : dsum;
			side_s7.b           <= b_s6;
			side_s7.a           <= a_s6;
			side_s7.flags.still <= still_s6;
			side_s7.flags.hit   <= !still_s6 && !dsum[ccti_pkg::DISC_W-1];
		end
	end

	assign disc = disc_s7;
	assign side = side_s7;

endmodule

`default_nettype wire

// ===== src/ccti_sqrt.sv =====
// ----------------------------------------------------------------------------
// ccti_sqrt
// Floor square root of the discriminant, one result bit per pipeline stage.
// ----------------------------------------------------------------------------
`default_nettype none

module ccti_sqrt (
	input  wire logic                                clk,
	input  wire logic                                en,
	input  wire logic [ccti_pkg::DISC_W-1:0]         rad,
	input  wire ccti_pkg::ccti_side_t                side_in,
	output logic [ccti_pkg::ROOT_W-1:0]              root,
	output ccti_pkg::ccti_side_t                     side_out
);

	localparam int RW  = ccti_pkg::ROOT_W;
	localparam int DW  = ccti_pkg::DISC_W;
	localparam int MW  = RW + 2;   // partial remainder

	logic [DW-1:0]        rad_s  [RW+1];
	logic [MW-1:0]        rem_s  [RW+1];
	logic [RW-1:0]        root_s [RW+1];
	ccti_pkg::ccti_side_t side_s [RW+1];

	// stage 0 is the module input
	assign rad_s[0]  = rad;
	assign rem_s[0]  = '0;
	assign root_s[0] = '0;
	assign side_s[0] = side_in;

	for (genvar k = 0; k < RW; k++) begin : g_step
		logic [MW-1:0] rem_sh, trial;
		logic          ge;

		// bring down two radicand bits, try root*4+1
		always_comb begin
			rem_sh = {rem_s[k][MW-3:0], rad_s[k][DW-1 -: 2]};
			trial  = {root_s[k], 2'b01};
			ge     = rem_sh >= trial;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1]  <= ge ? rem_sh - trial : rem_sh;
				root_s[k+1] <= {root_s[k][RW-2:0], ge};
				rad_s[k+1]  <= {rad_s[k][DW-3:0], 2'b00};
				side_s[k+1] <= side_s[k];
			end
		end
	end

	assign root     = root_s[RW];
	assign side_out = side_s[RW];

endmodule

`default_nettype wire

// ===== src/ccti_div.sv =====
// ----------------------------------------------------------------------------
// ccti_div
// Numerator -(d.w) - root, then a restoring divide by w.w that keeps the
// low quotient bits and flags overflow, one quotient bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module ccti_div #(
	parameter int FRAC_BITS = 16
) (
	input  wire logic                                clk,
	input  wire logic                                en,
	input  wire logic [ccti_pkg::ROOT_W-1:0]         root,
	input  wire ccti_pkg::ccti_side_t                side_in,
	output ccti_pkg::ccti_quot_t                     quot,
	output ccti_pkg::ccti_flags_t                    flags
);

	localparam int AW   = ccti_pkg::A_W;
	localparam int QW   = ccti_pkg::Q_W;
	localparam int NMW  = ccti_pkg::NMAG_W;
	localparam int NUMW = ccti_pkg::NUM_W;
	localparam int NW   = NMW + FRAC_BITS;   // scaled numerator
	localparam int TW   = NW - QW;           // bits above the kept quotient

	// s1: signed numerator and its magnitude
	logic [NUMW-1:0] num, num_neg;
	assign num = -{side_in.b[ccti_pkg::B_W-1], side_in.b}
		- {{(NUMW-ccti_pkg::ROOT_W){1'b0}}, root};
	assign num_neg = -num;

	logic [NMW-1:0]        nmag_s1;
	logic                  neg_s1;
	logic [AW-1:0]         a_s1;
	ccti_pkg::ccti_flags_t flags_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			neg_s1   <= num[NUMW-1];
			nmag_s1  <= num[NUMW-1] ? num_neg[NMW-1:0] : num[NMW-1:0];
			a_s1     <= side_in.a;
			flags_s1 <= side_in.flags;
		end
	end

	// s2: overflow test on the upper part, seeds the partial remainder
	logic [NW-1:0] numer;
	logic [AW-1:0] top_ext;
	assign numer   = {nmag_s1, {FRAC_BITS{1'b0}}};
	assign top_ext = {{(AW-TW){1'b0}}, numer[NW-1:QW]};

	logic [AW-1:0]         rem_s   [QW+1];
	logic [QW-1:0]         lo_s    [QW+1];
	logic [QW-1:0]         q_s     [QW+1];
	logic [AW-1:0]         a_s     [QW+1];
	logic                  ovf_s   [QW+1];
	logic                  neg_s   [QW+1];
	ccti_pkg::ccti_flags_t flags_s [QW+1];

	always_ff @(posedge clk) begin
		if (en) begin
			ovf_s[0]   <= top_ext >= a_s1;
			rem_s[0]   <= (top_ext >= a_s1) ? '0 : top_ext;
			lo_s[0]    <= numer[QW-1:0];
			q_s[0]     <= '0;
			a_s[0]     <= a_s1;
			neg_s[0]   <= neg_s1;
			flags_s[0] <= flags_s1;
		end
	end

	// quotient bits, most significant first
	for (genvar k = 0; k < QW; k++) begin : g_step
		logic [AW:0] rem_sh;
		logic        ge;

		always_comb begin
			rem_sh = {rem_s[k], lo_s[k][QW-1]};
			ge     = rem_sh >= {1'b0, a_s[k]};
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1]   <= ge ? AW'(rem_sh - {1'b0, a_s[k]}) : rem_sh[AW-1:0];
				q_s[k+1]     <= {q_s[k][QW-2:0], ge};
				lo_s[k+1]    <= {lo_s[k][QW-2:0], 1'b0};
				a_s[k+1]     <= a_s[k];
				ovf_s[k+1]   <= ovf_s[k];
				neg_s[k+1]   <= neg_s[k];
				flags_s[k+1] <= flags_s[k];
			end
		end
	end

	assign quot.ovf    = ovf_s[QW];
	assign quot.neg    = neg_s[QW];
	assign quot.rem_nz = rem_s[QW] != '0;
	assign quot.q      = q_s[QW];
	assign flags       = flags_s[QW];

endmodule

`default_nettype wire

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the circle-circle time-of-impact pipeline.
// ----------------------------------------------------------------------------
// A short table of directed circle pairs runs first. Random pairs follow,
// most at small scale so that contacts are common. Each accepted item without
// a typed answer goes through a wide-integer contact solver. Each result is
// compared in order with the oldest expected answer. Both channels idle at
// random. One long output hold-off fills the pipeline and stalls its input.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

	localparam int FRAC       = 16;
	localparam int NUM_RANDOM = 750;
	localparam int CYCLE_CAP  = 400000;
	localparam int QUIET_LO   = 800;
	localparam int QUIET_HI   = 1100;
	localparam int HOLD_AT    = 200;
	localparam int HOLD_LEN   = 400;

	typedef logic signed [199:0] wide_t;

	typedef struct packed {
		logic                        hit;
		logic [ccti_pkg::TIME_W-1:0] t;
		logic                        still;
	} impact_t;

	typedef struct {
		ccti_pkg::ccti_in_t pair;
		bit                 typed;
		impact_t            answer;
	} vector_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int   cycle = 0;
	int   errors = 0;
	int   accepted = 0;
	bit   stim_done = 0;

	impact_t pending[$];
	vector_t vectors[$];

	ccti_in_if  pairs();
	ccti_out_if results();

	circle_circle_time_of_impact #(.FRAC_BITS(FRAC)) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.pairs   (pairs.sink),
		.results (results.source)
	);

	always #6 clk = ~clk;

	// cycle count and run limit
	always @(posedge clk) begin
		cycle <= cycle + 1;
		if (cycle > CYCLE_CAP) begin
			$display("FAILURE");
			$finish;
		end
	end

	// solve |d + w t| = r1 + r2 for the earlier root in exact integers
	function automatic impact_t solve_contact(ccti_pkg::ccti_in_t p);
		wide_t dx, dy, wx, wy, rs, b, a, c, disc, root, cand, num, mag, q, r;
		bit neg;
		impact_t res;
		dx = wide_t'($signed(p.first_pos_x)) - wide_t'($signed(p.second_pos_x));
		dy = wide_t'($signed(p.first_pos_y)) - wide_t'($signed(p.second_pos_y));
		wx = wide_t'($signed(p.first_vel_x)) - wide_t'($signed(p.second_vel_x));
		wy = wide_t'($signed(p.first_vel_y)) - wide_t'($signed(p.second_vel_y));
		rs = wide_t'({1'b0, p.first_radius}) + wide_t'({1'b0, p.second_radius});
		b = dx * wx + dy * wy;
		a = wx * wx + wy * wy;
		c = dx * dx + dy * dy - rs * rs;
		res = '0;
		if (a == 0) begin
			res.still = 1'b1;
			return res;
		end
		disc = b * b - a * c;
		if (disc < 0) return res;
		res.hit = 1'b1;
		root = 0;
		for (int i = 71; i >= 0; i--) begin
			cand = root | (wide_t'(1) <<< i);
			if (cand * cand <= disc) root = cand;
		end
		num = -b - root;
		neg = num < 0;
		mag = (neg ? -num : num) <<< FRAC;
		q = mag / a;
		r = mag % a;
		if (neg && r != 0) q = q + 1;
		if (!neg) begin
			res.t = (q > wide_t'(32'h7FFF_FFFF)) ? ccti_pkg::TIME_MAX
				: q[ccti_pkg::TIME_W-1:0];
		end else begin
			q = -q;
			res.t = (q < -wide_t'(33'h0_8000_0000)) ? ccti_pkg::TIME_MIN
				: q[ccti_pkg::TIME_W-1:0];
		end
		return res;
	endfunction

	function automatic logic [31:0] corner32();
		case ($urandom_range(0, 3))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return 32'h0;
			default: return 32'hFFFF_FFFF;
		endcase
	endfunction

	function automatic logic [31:0] near(int span);
		return 32'($signed($urandom_range(0, 2 * span)) - span);
	endfunction

	// random pair: mostly small scale for frequent contacts
	function automatic ccti_pkg::ccti_in_t random_pair();
		ccti_pkg::ccti_in_t p;
		int mode;
		mode = $urandom_range(0, 9);
		if (mode == 0) begin
			p.first_pos_x   = $urandom();
			p.first_pos_y   = $urandom();
			p.second_pos_x  = $urandom();
			p.second_pos_y  = $urandom();
			p.first_vel_x   = $urandom();
			p.first_vel_y   = $urandom();
			p.second_vel_x  = $urandom();
			p.second_vel_y  = $urandom();
			p.first_radius  = ccti_pkg::RAD_W'($urandom());
			p.second_radius = ccti_pkg::RAD_W'($urandom());
		end else if (mode == 1) begin
			p.first_pos_x  = corner32(); p.first_pos_y  = corner32();
			p.second_pos_x = corner32(); p.second_pos_y = corner32();
			p.first_vel_x  = corner32(); p.first_vel_y  = corner32();
			p.second_vel_x = corner32(); p.second_vel_y = corner32();
			p.first_radius  = ccti_pkg::RAD_W'(corner32());
			p.second_radius = ccti_pkg::RAD_W'(corner32());
		end else begin
			p.first_pos_x  = near(1 << 22); p.first_pos_y  = near(1 << 22);
			p.second_pos_x = near(1 << 22); p.second_pos_y = near(1 << 22);
			p.first_vel_x  = near(1 << 19); p.first_vel_y  = near(1 << 19);
			p.second_vel_x = near(1 << 19); p.second_vel_y = near(1 << 19);
			p.first_radius  = ccti_pkg::RAD_W'($urandom_range(0, 1 << 21));
			p.second_radius = ccti_pkg::RAD_W'($urandom_range(0, 1 << 21));
			// equal velocities: no relative motion
			if (mode == 2) begin
				p.second_vel_x = p.first_vel_x;
				p.second_vel_y = p.first_vel_y;
			end
		end
		return p;
	endfunction

	function automatic vector_t row(logic [31:0] p1x, p1y, p2x, p2y, v1x, v1y, v2x, v2y,
	                                logic [30:0] r1, r2, bit typed = 0,
	                                impact_t ans = '0);
		vector_t v;
		v.pair = {p1x, p1y, p2x, p2y, v1x, v1y, v2x, v2y, r1, r2};
		v.typed = typed;
		v.answer = ans;
		return v;
	endfunction

	// directed table
	initial begin
		vectors.push_back(row(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1, '{0, 0, 1}));
		vectors.push_back(row(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
		                      5, 5, 5, 5, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 1, '{0, 0, 1}));
		// head-on approach along x, contact at t = 8
		vectors.push_back(row(0, 0, 32'h000A_0000, 0, 32'h0001_0000, 0, 0, 0,
		                      31'h0001_0000, 31'h0001_0000));
		// overlapping at start: negative root
		vectors.push_back(row(0, 0, 32'h0000_8000, 0, 32'h0001_0000, 0, 0, 0,
		                      31'h0001_0000, 31'h0001_0000));
		// receding circles whose lines met earlier
		vectors.push_back(row(0, 0, 32'h000A_0000, 0, 32'hFFFF_0000, 0, 0, 0,
		                      31'h0001_0000, 0));
		// passing wide: negative discriminant
		vectors.push_back(row(0, 0, 32'h000A_0000, 32'h0064_0000, 32'h0001_0000, 0, 0, 0,
		                      31'h0001_0000, 31'h0001_0000, 1, '{0, 0, 0}));
		// grazing contact, zero radii
		vectors.push_back(row(0, 0, 32'h0005_0000, 0, 32'h0001_0000, 0, 0, 0, 0, 0));
		// far away, crawling: saturates high
		vectors.push_back(row(32'h8000_0000, 0, 32'h7FFF_FFFF, 0, 1, 0, 0, 0, 1, 1));
		// far behind, crawling away: saturates low
		vectors.push_back(row(32'h8000_0000, 0, 32'h7FFF_FFFF, 0, 32'hFFFF_FFFF, 0, 0, 0,
		                      1, 1));
		// extreme velocities and radii
		vectors.push_back(row(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
		                      32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
		                      31'h7FFF_FFFF, 31'h7FFF_FFFF));
		vectors.push_back(row(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
		                      32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
		                      31'h7FFF_FFFF, 0));
		vectors.push_back(row(32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0, 32'hFFFF_FFFF,
		                      32'hFFFF_FFFF, 0, 0, 0, 31'h7FFF_FFFF));
		vectors.push_back(row(0, 0, 0, 0, 0, 32'h0000_0001, 0, 0, 0, 0));
		vectors.push_back(row(0, 32'h0003_0000, 32'h0004_0000, 0, 0, 0,
		                      32'hFFFF_0000, 32'h0000_C000, 31'h0000_8000, 31'h0000_8000));
		for (int i = 0; i < NUM_RANDOM; i++) vectors.push_back(row(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
	end

	// sender
	initial begin
		vector_t v;
		pairs.valid <= 1'b0;
		pairs.first_pos_x <= '0;  pairs.first_pos_y <= '0;
		pairs.second_pos_x <= '0; pairs.second_pos_y <= '0;
		pairs.first_vel_x <= '0;  pairs.first_vel_y <= '0;
		pairs.second_vel_x <= '0; pairs.second_vel_y <= '0;
		pairs.first_radius <= '0; pairs.second_radius <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (int n = 0; n < vectors.size(); n++) begin
			v = vectors[n];
			if (n >= vectors.size() - NUM_RANDOM) v.pair = random_pair();
			// random gaps, none inside the quiet window
			while (!(cycle >= QUIET_LO && cycle < QUIET_HI) && $urandom_range(0, 99) < 20) begin
				pairs.valid <= 1'b0;
				@(posedge clk);
			end
			pairs.valid         <= 1'b1;
			pairs.first_pos_x   <= v.pair.first_pos_x;
			pairs.first_pos_y   <= v.pair.first_pos_y;
			pairs.second_pos_x  <= v.pair.second_pos_x;
			pairs.second_pos_y  <= v.pair.second_pos_y;
			pairs.first_vel_x   <= v.pair.first_vel_x;
			pairs.first_vel_y   <= v.pair.first_vel_y;
			pairs.second_vel_x  <= v.pair.second_vel_x;
			pairs.second_vel_y  <= v.pair.second_vel_y;
			pairs.first_radius  <= v.pair.first_radius;
			pairs.second_radius <= v.pair.second_radius;
			do @(posedge clk); while (!pairs.ready);
			pending.push_back(v.typed ? v.answer : solve_contact(v.pair));
			accepted++;
		end
		pairs.valid <= 1'b0;
		stim_done = 1;
	end

	// receiver: random stalls, one long hold-off, in-order check
	int hold_left = 0;
	bit hold_done = 0;
	always @(posedge clk) begin
		impact_t e;
		if (!arst_n) begin
			results.ready <= 1'b0;
		end else begin
			if (results.valid && results.ready) begin
				if (pending.size() == 0) begin
					$error("result with nothing expected");
					errors++;
				end else begin
					e = pending.pop_front();
					if (results.hit !== e.hit) begin
						$error("hit: expected %0d, got %0d", e.hit, results.hit);
						errors++;
					end
					if (results.impact_time !== e.t) begin
						$error("impact_time: expected %h, got %h", e.t, results.impact_time);
						errors++;
					end
					if (results.no_relative_motion !== e.still) begin
						$error("no_relative_motion: expected %0d, got %0d", e.still,
						       results.no_relative_motion);
						errors++;
					end
				end
			end
			if (!hold_done && accepted >= HOLD_AT) begin
				hold_done = 1;
				hold_left = HOLD_LEN;
			end
			if (hold_left > 0) begin
				hold_left--;
				results.ready <= 1'b0;
			end else if (cycle >= QUIET_LO && cycle < QUIET_HI) begin
				results.ready <= 1'b1;
			end else begin
				results.ready <= ($urandom_range(0, 99) >= 20);
			end
		end
	end

	// drain and report
	initial begin
		wait (stim_done);
		while (pending.size() != 0) @(posedge clk);
		repeat (ccti_pkg::LAT + 20) @(posedge clk);
		if (errors == 0 && pending.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
